>>> rtl/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, codes and beat types of the COO to CSR converter.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MAX_ROWS    = 4096;
  localparam int MAX_LOADED  = 4096;
  localparam int MAX_ENTRIES = 8192;

  localparam int IDX_W = 12;                       // row / column field width
  localparam int VAL_W = 64;
  localparam int RW    = $clog2(MAX_ROWS);         // row store address
  localparam int RCW   = RW + 1;                   // row count
  localparam int LAW   = $clog2(MAX_LOADED);       // load store address
  localparam int LCW   = LAW + 1;                  // load count
  localparam int BAW   = $clog2(MAX_ENTRIES);      // bucket address
  localparam int CW    = BAW + 1;                  // entry count / offsets
  localparam int PW    = CW + 1;                   // readout pointer

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_CONV  = 2'd1;
  localparam logic [1:0] FN_FETCH = 2'd2;

  localparam logic [1:0] K_STATUS = 2'd0;
  localparam logic [1:0] K_ROW    = 2'd1;
  localparam logic [1:0] K_ENTRY  = 2'd2;
  localparam logic [1:0] K_EMPTY  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_SYM  = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [VAL_W-1:0] value_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [13:0]      row_start;
    logic [IDX_W-1:0] out_col;
    logic [VAL_W-1:0] out_value_bits;
    logic             last;
    logic             error;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } ld_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] val;
  } bk_ent_t;

  typedef struct packed {
    logic           we;
    logic [LAW-1:0] waddr;
    ld_ent_t        wdata;
    logic           re;
    logic [LAW-1:0] raddr;
  } ld_req_t;

  typedef struct packed {
    logic          we;
    logic [RW-1:0] waddr;
    logic [CW-1:0] wdata;
    logic          re;
    logic [RW-1:0] raddr;
  } fl_req_t;

  typedef struct packed {
    logic           we;
    logic [RCW-1:0] waddr;
    logic [CW-1:0]  wdata;
    logic           re;
    logic [RCW-1:0] raddr;
  } rs_req_t;

  typedef struct packed {
    logic           we;
    logic [BAW-1:0] waddr;
    bk_ent_t        wdata;
    logic           re;
    logic [BAW-1:0] raddr;
  } bk_req_t;

endpackage

>>> rtl/sparse_coo_to_csr_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_coo_to_csr_converter
// Coordinate-format entry loader and compressed-row builder with readout.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat carries a func code. A load beat stores (row, col, value)
//   and gives no result. A convert beat runs the whole build: clear the row
//   counters of the effective row count, count the entries, prefix-sum the
//   row starts, scatter, then insertion-sort every row by column, and
//   return one status beat with the total entry count. The sort loop over
//   the bucket store sets the convert time; it is quadratic in the longest
//   row. A fetch beat reads one row start or one entry through the
//   registered memory read, or returns an empty beat (kind 3) when nothing
//   is left.
//   A single sequencer drives every store; in_ready stays low while it works
//   and while a result beat waits in the output register.
//   Reset (synchronous, rst_n low) clears the load count, readout pointer,
//   error flag and held conversion; the memories need no clearing pass.
//   A stalled receiver holds the result beat in place and blocks new input.
//   Configuration (row_count at 0x0, symmetric_mode at 0x4) is written over
//   the APB port while idle; a convert captures it.
// ----------------------------------------------------------------------------
module sparse_coo_to_csr_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  scc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scc_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RCW = scc_pkg::RCW;
  localparam int LCW = scc_pkg::LCW;
  localparam int CW  = scc_pkg::CW;
  localparam int PW  = scc_pkg::PW;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_CLR    = 20'h00002,
    S_P1_RD  = 20'h00004,
    S_P1_CHK = 20'h00008,
    S_P1_R   = 20'h00010,
    S_P1_C   = 20'h00020,
    S_PF_RD  = 20'h00040,
    S_PF_WR  = 20'h00080,
    S_P2_RD  = 20'h00100,
    S_P2_CHK = 20'h00200,
    S_P2_R   = 20'h00400,
    S_P2_C   = 20'h00800,
    S_SR_A   = 20'h01000,
    S_SR_B   = 20'h02000,
    S_SR_C   = 20'h04000,
    S_SK     = 20'h08000,
    S_SK2    = 20'h10000,
    S_SJ     = 20'h20000,
    S_SPUT   = 20'h40000,
    S_DONE   = 20'h80000
  } state_t;

  // fetch read pending is tracked by ft_r alongside S_IDLE
  state_t             st_r, st_nxt;
  logic               ft_r, ft_nxt;
  logic               ft_row_r, ft_row_nxt;
  logic               ft_last_r, ft_last_nxt;

  logic [RCW-1:0]     cfg_rows_r;
  logic               cfg_sym_r;

  logic [RCW-1:0]     rc_r, rc_nxt;
  logic               sym_r, sym_nxt;
  logic [RCW-1:0]     ri_r, ri_nxt;
  logic [LCW-1:0]     ii_r, ii_nxt;
  logic [LCW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]      tot_r, tot_nxt;
  logic [CW-1:0]      acc_r, acc_nxt;
  logic               n2_r, n2_nxt;
  logic [CW-1:0]      s_r, s_nxt;
  logic [CW-1:0]      e_r, e_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  scc_pkg::bk_ent_t   key_r, key_nxt;
  logic               err_r, err_nxt;
  logic               held_r, held_nxt;
  logic [RCW-1:0]     hrows_r, hrows_nxt;
  logic [CW-1:0]      htot_r, htot_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic               out_valid_r, out_valid_nxt;
  scc_pkg::out_item_t out_r, out_nxt;

  scc_pkg::ld_req_t   ld_req;
  scc_pkg::fl_req_t   fl_req;
  scc_pkg::rs_req_t   rs_req;
  scc_pkg::bk_req_t   bk_req;
  scc_pkg::ld_ent_t   ld_q;
  logic [CW-1:0]      fl_q;
  logic [CW-1:0]      rs_q;
  scc_pkg::bk_ent_t   bk_q;

  scc_mem u_mem (
    .clk    (clk),
    .ld_req (ld_req),
    .fl_req (fl_req),
    .rs_req (rs_req),
    .bk_req (bk_req),
    .ld_q   (ld_q),
    .fl_q   (fl_q),
    .rs_q   (rs_q),
    .bk_q   (bk_q)
  );

  // ---------------- configuration port ----------------
  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r <= RCW'(scc_pkg::MAX_ROWS);
      cfg_sym_r  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == scc_pkg::REG_ROWS) cfg_rows_r <= pwdata[RCW-1:0];
      else                               cfg_sym_r  <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == scc_pkg::REG_ROWS) prdata[RCW-1:0] = cfg_rows_r;
    else                               prdata[0]       = cfg_sym_r;
  end

  // ---------------- shared datapath terms ----------------
  logic           in_acc;
  logic [RCW-1:0] rc_eff;
  logic           keep;
  logic [CW:0]    need;
  logic [CW:0]    tot_sum;
  logic [CW-1:0]  pf_sum;
  logic [PW-1:0]  rp_lim;
  logic [PW-1:0]  rp_ent;

  assign in_ready  = (st_r == S_IDLE) && !ft_r && !out_valid_r;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (cfg_rows_r == '0)                            rc_eff = RCW'(1);
    else if (cfg_rows_r > RCW'(scc_pkg::MAX_ROWS))   rc_eff = RCW'(scc_pkg::MAX_ROWS);
    else                                             rc_eff = cfg_rows_r;
  end

  // keep rule for the entry sitting in the load read register
  assign keep    = ({1'b0, ld_q.row} < rc_r) && ({1'b0, ld_q.col} < rc_r);
  assign need    = (sym_r && (ld_q.row != ld_q.col)) ? (CW+1)'(2) : (CW+1)'(1);
  assign tot_sum = {1'b0, tot_r} + need;
  assign pf_sum  = acc_r + fl_q;
  assign rp_lim  = PW'(hrows_r) + PW'(htot_r) + PW'(1);
  assign rp_ent  = rp_r - PW'(hrows_r) - PW'(1);

  always_comb begin
    st_nxt        = st_r;
    ft_nxt        = 1'b0;
    ft_row_nxt    = ft_row_r;
    ft_last_nxt   = ft_last_r;
    rc_nxt        = rc_r;
    sym_nxt       = sym_r;
    ri_nxt        = ri_r;
    ii_nxt        = ii_r;
    cnt_nxt       = cnt_r;
    tot_nxt       = tot_r;
    acc_nxt       = acc_r;
    n2_nxt        = n2_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    err_nxt       = err_r;
    held_nxt      = held_r;
    hrows_nxt     = hrows_r;
    htot_nxt      = htot_r;
    rp_nxt        = rp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ld_req        = '0;
    fl_req        = '0;
    rs_req        = '0;
    bk_req        = '0;

    case (st_r)
      S_IDLE: begin
        if (ft_r) begin
          // fetch read returns: emit the beat, advance the pointer
          out_nxt       = '0;
          out_nxt.error = err_r;
          out_nxt.last  = ft_last_r;
          if (ft_row_r) begin
            out_nxt.kind      = scc_pkg::K_ROW;
            out_nxt.row_start = rs_q;
          end else begin
            out_nxt.kind           = scc_pkg::K_ENTRY;
            out_nxt.out_col        = bk_q.col;
            out_nxt.out_value_bits = bk_q.val;
          end
          out_valid_nxt = 1'b1;
          rp_nxt        = rp_r + PW'(1);
        end else if (in_acc) begin
          case (in_data.func)
            scc_pkg::FN_LOAD: begin
              if (cnt_r >= LCW'(scc_pkg::MAX_LOADED)) begin
                err_nxt = 1'b1;
              end else begin
                ld_req.we        = 1'b1;
                ld_req.waddr     = cnt_r[scc_pkg::LAW-1:0];
                ld_req.wdata.row = in_data.row_index;
                ld_req.wdata.col = in_data.col_index;
                ld_req.wdata.val = in_data.value_bits;
                cnt_nxt          = cnt_r + LCW'(1);
              end
            end
            scc_pkg::FN_CONV: begin
              rc_nxt  = rc_eff;
              sym_nxt = cfg_sym_r;
              ri_nxt  = '0;
              st_nxt  = S_CLR;
            end
            scc_pkg::FN_FETCH: begin
              if (!held_r || rp_r >= rp_lim) begin
                out_nxt       = '0;
                out_nxt.kind  = scc_pkg::K_EMPTY;
                out_nxt.error = err_r;
                out_valid_nxt = 1'b1;
              end else if (rp_r <= PW'(hrows_r)) begin
                rs_req.re   = 1'b1;
                rs_req.raddr = rp_r[RCW-1:0];
                ft_nxt      = 1'b1;
                ft_row_nxt  = 1'b1;
                ft_last_nxt = (rp_r == PW'(hrows_r));
              end else begin
                bk_req.re    = 1'b1;
                bk_req.raddr = rp_ent[scc_pkg::BAW-1:0];
                ft_nxt       = 1'b1;
                ft_row_nxt   = 1'b0;
                ft_last_nxt  = ((rp_ent + PW'(1)) == PW'(htot_r));
              end
            end
            default: ;
          endcase
        end
      end

      // clear the fill counters of the rows in use
      S_CLR: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = ri_r[scc_pkg::RW-1:0];
        fl_req.wdata = '0;
        if (ri_r == '0) begin
          rs_req.we    = 1'b1;
          rs_req.waddr = '0;
          rs_req.wdata = '0;
        end
        ri_nxt = ri_r + RCW'(1);
        if (ri_r + RCW'(1) == rc_r) begin
          ii_nxt  = '0;
          tot_nxt = '0;
          st_nxt  = S_P1_RD;
        end
      end

      // count pass
      S_P1_RD: begin
        if (ii_r == cnt_r) begin
          ri_nxt  = '0;
          acc_nxt = '0;
          st_nxt  = S_PF_RD;
        end else begin
          ld_req.re    = 1'b1;
          ld_req.raddr = ii_r[scc_pkg::LAW-1:0];
          st_nxt       = S_P1_CHK;
        end
      end
      S_P1_CHK: begin
        if (!keep || tot_sum > (CW+1)'(scc_pkg::MAX_ENTRIES)) begin
          err_nxt = 1'b1;
          ii_nxt  = ii_r + LCW'(1);
          st_nxt  = S_P1_RD;
        end else begin
          tot_nxt      = tot_sum[CW-1:0];
          n2_nxt       = need[1];
          fl_req.re    = 1'b1;
          fl_req.raddr = ld_q.row;
          st_nxt       = S_P1_R;
        end
      end
      S_P1_R: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = ld_q.row;
        fl_req.wdata = fl_q + CW'(1);
        if (n2_r) begin
          fl_req.re    = 1'b1;
          fl_req.raddr = ld_q.col;
          st_nxt       = S_P1_C;
        end else begin
          ii_nxt = ii_r + LCW'(1);
          st_nxt = S_P1_RD;
        end
      end
      S_P1_C: begin
        fl_req.we    = 1'b1;
        fl_req.waddr = ld_q.col;
        fl_req.wdata = fl_q + CW'(1);
        ii_nxt       = ii_r + LCW'(1);
        st_nxt       = S_P1_RD;
      end

      // prefix sum: row_starts[r+1], and turn each counter into a write pointer
      S_PF_RD: begin
        fl_req.re    = 1'b1;
        fl_req.raddr = ri_r[scc_pkg::RW-1:0];
        st_nxt       = S_PF_WR;
      end
      S_PF_WR: begin
        rs_req.we    = 1'b1;
        rs_req.waddr = ri_r + RCW'(1);
        rs_req.wdata = pf_sum;
        fl_req.we    = 1'b1;
        fl_req.waddr = ri_r[scc_pkg::RW-1:0];
        fl_req.wdata = acc_r;
        acc_nxt      = pf_sum;
        ri_nxt       = ri_r + RCW'(1);
        if (ri_r + RCW'(1) == rc_r) begin
          ii_nxt  = '0;
          tot_nxt = '0;
          st_nxt  = S_P2_RD;
        end else begin
          st_nxt = S_PF_RD;
        end
      end

      // scatter pass
      S_P2_RD: begin
        if (ii_r == cnt_r) begin
          ri_nxt = '0;
          st_nxt = S_SR_A;
        end else begin
          ld_req.re    = 1'b1;
          ld_req.raddr = ii_r[scc_pkg::LAW-1:0];
          st_nxt       = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        if (!keep || tot_sum > (CW+1)'(scc_pkg::MAX_ENTRIES)) begin
          ii_nxt = ii_r + LCW'(1);
          st_nxt = S_P2_RD;
        end else begin
          tot_nxt      = tot_sum[CW-1:0];
          n2_nxt       = need[1];
          fl_req.re    = 1'b1;
          fl_req.raddr = ld_q.row;
          st_nxt       = S_P2_R;
        end
      end
      S_P2_R: begin
        bk_req.we        = 1'b1;
        bk_req.waddr     = fl_q[scc_pkg::BAW-1:0];
        bk_req.wdata.col = ld_q.col;
        bk_req.wdata.val = ld_q.val;
        fl_req.we        = 1'b1;
        fl_req.waddr     = ld_q.row;
        fl_req.wdata     = fl_q + CW'(1);
        if (n2_r) begin
          fl_req.re    = 1'b1;
          fl_req.raddr = ld_q.col;
          st_nxt       = S_P2_C;
        end else begin
          ii_nxt = ii_r + LCW'(1);
          st_nxt = S_P2_RD;
        end
      end
      S_P2_C: begin
        bk_req.we        = 1'b1;
        bk_req.waddr     = fl_q[scc_pkg::BAW-1:0];
        bk_req.wdata.col = ld_q.row;
        bk_req.wdata.val = ld_q.val;
        fl_req.we        = 1'b1;
        fl_req.waddr     = ld_q.col;
        fl_req.wdata     = fl_q + CW'(1);
        ii_nxt           = ii_r + LCW'(1);
        st_nxt           = S_P2_RD;
      end

      // per-row stable insertion sort by column
      S_SR_A: begin
        rs_req.re    = 1'b1;
        rs_req.raddr = ri_r;
        st_nxt       = S_SR_B;
      end
      S_SR_B: begin
        s_nxt        = rs_q;
        rs_req.re    = 1'b1;
        rs_req.raddr = ri_r + RCW'(1);
        st_nxt       = S_SR_C;
      end
      S_SR_C: begin
        e_nxt  = rs_q;
        k_nxt  = s_r + CW'(1);
        st_nxt = S_SK;
      end
      S_SK: begin
        if (k_r >= e_r) begin
          ri_nxt = ri_r + RCW'(1);
          st_nxt = (ri_r + RCW'(1) == rc_r) ? S_DONE : S_SR_A;
        end else begin
          bk_req.re    = 1'b1;
          bk_req.raddr = k_r[scc_pkg::BAW-1:0];
          st_nxt       = S_SK2;
        end
      end
      S_SK2: begin
        key_nxt      = bk_q;
        j_nxt        = k_r;
        bk_req.re    = 1'b1;
        bk_req.raddr = k_r[scc_pkg::BAW-1:0] - scc_pkg::BAW'(1);
        st_nxt       = S_SJ;
      end
      S_SJ: begin
        bk_req.we    = 1'b1;
        bk_req.waddr = j_r[scc_pkg::BAW-1:0];
        if (bk_q.col > key_r.col) begin
          // shift the larger neighbor up, look one further down
          bk_req.wdata = bk_q;
          j_nxt        = j_r - CW'(1);
          if (j_r - CW'(1) > s_r) begin
            bk_req.re    = 1'b1;
            bk_req.raddr = j_r[scc_pkg::BAW-1:0] - scc_pkg::BAW'(2);
          end else begin
            st_nxt = S_SPUT;
          end
        end else begin
          bk_req.wdata = key_r;
          k_nxt        = k_r + CW'(1);
          st_nxt       = S_SK;
        end
      end
      S_SPUT: begin
        bk_req.we    = 1'b1;
        bk_req.waddr = j_r[scc_pkg::BAW-1:0];
        bk_req.wdata = key_r;
        k_nxt        = k_r + CW'(1);
        st_nxt       = S_SK;
      end

      S_DONE: begin
        out_nxt           = '0;
        out_nxt.kind      = scc_pkg::K_STATUS;
        out_nxt.row_start = tot_r;
        out_nxt.error     = err_r;
        out_valid_nxt     = 1'b1;
        held_nxt          = 1'b1;
        hrows_nxt         = rc_r;
        htot_nxt          = tot_r;
        rp_nxt            = '0;
        st_nxt            = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ft_r        <= 1'b0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      held_r      <= 1'b0;
      hrows_r     <= RCW'(1);
      htot_r      <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ft_r        <= ft_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      held_r      <= held_nxt;
      hrows_r     <= hrows_nxt;
      htot_r      <= htot_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ft_row_r  <= ft_row_nxt;
    ft_last_r <= ft_last_nxt;
    rc_r      <= rc_nxt;
    sym_r     <= sym_nxt;
    ri_r      <= ri_nxt;
    ii_r      <= ii_nxt;
    tot_r     <= tot_nxt;
    acc_r     <= acc_nxt;
    n2_r      <= n2_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    key_r     <= key_nxt;
    out_r     <= out_nxt;
  end

  // ---------------- checks ----------------
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r) else $error("error flag cleared without reset");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LCW'(scc_pkg::MAX_LOADED)) else $error("load count past capacity");

  a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> rp_r <= rp_lim) else $error("readout pointer past end");

  a_fetch_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ft_r |=> out_valid_r) else $error("fetch read gave no result beat");

endmodule

>>> rtl/scc_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_mem
// Load store, row fill counters, row starts and bucket store; one write and
// one registered read per store each cycle.
// ----------------------------------------------------------------------------
module scc_mem (
  input  logic                           clk,
  input  scc_pkg::ld_req_t               ld_req,
  input  scc_pkg::fl_req_t               fl_req,
  input  scc_pkg::rs_req_t               rs_req,
  input  scc_pkg::bk_req_t               bk_req,
  output scc_pkg::ld_ent_t               ld_q,
  output logic [scc_pkg::CW-1:0]         fl_q,
  output logic [scc_pkg::CW-1:0]         rs_q,
  output scc_pkg::bk_ent_t               bk_q
);

  scc_pkg::ld_ent_t        ld_mem [scc_pkg::MAX_LOADED];
  logic [scc_pkg::CW-1:0]  fl_mem [scc_pkg::MAX_ROWS];
  logic [scc_pkg::CW-1:0]  rs_mem [scc_pkg::MAX_ROWS+1];
  scc_pkg::bk_ent_t        bk_mem [scc_pkg::MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (ld_req.we) ld_mem[ld_req.waddr] <= ld_req.wdata;
    if (ld_req.re) ld_q <= ld_mem[ld_req.raddr];
  end

  always_ff @(posedge clk) begin
    if (fl_req.we) fl_mem[fl_req.waddr] <= fl_req.wdata;
    if (fl_req.re) fl_q <= fl_mem[fl_req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rs_req.we) rs_mem[rs_req.waddr] <= rs_req.wdata;
    if (rs_req.re) rs_q <= rs_mem[rs_req.raddr];
  end

  always_ff @(posedge clk) begin
    if (bk_req.we) bk_mem[bk_req.waddr] <= bk_req.wdata;
    if (bk_req.re) bk_q <= bk_mem[bk_req.raddr];
  end

endmodule
